>>> src/conv3x3_rgb_clamp_filter_assert.svh
// assertion macros for the 3x3 rgb filter checker
// expects signals named clk and rst in the scope where they are used
`ifndef CONV3X3_RGB_CLAMP_FILTER_ASSERT_SVH
`define CONV3X3_RGB_CLAMP_FILTER_ASSERT_SVH

// same-cycle implication, off during reset
`define C3RGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c3rgb: same-cycle check failed");

// next-cycle implication, off during reset
`define C3RGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c3rgb: next-cycle check failed");

// next-cycle implication that also holds across reset
`define C3RGB_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c3rgb: reset check failed");

`endif

>>> src/c3rgb_pkg.sv
// shared constants for the 3x3 rgb convolution filter
// no dependencies
package c3rgb_pkg;

  localparam int CH_W      = 8;
  localparam int NCH       = 3;
  localparam int PIX_W     = NCH * CH_W;
  localparam int SIZE_W    = 11;
  localparam int CFG_IDX_W = 3;
  localparam int KROW_MAX  = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

  // reset kernel rows, cut to the row width in use
  localparam logic [KROW_MAX-1:0] KTOP_RST = 48'h0000_00FF_FFFF;
  localparam logic [KROW_MAX-1:0] KMID_RST = 48'h0000_00FF_08FF;
  localparam logic [KROW_MAX-1:0] KBOT_RST = 48'h0000_00FF_FFFF;

  localparam logic [CH_W-1:0] PIX_MAX = 8'd255;
  localparam logic [CH_W-1:0] PIX_MIN = 8'd0;

endpackage

>>> src/c3rgb_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module c3rgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/conv3x3_rgb_clamp_filter.sv
// 3x3 rgb convolution with zero padding and clamp, top level
// depends on c3rgb_pkg and c3rgb_ram
//
// Pixels of a frame enter in raster order, one word per clock, and the block
// sustains one word per clock in both directions while pix_stall is low. Each
// output pixel leaves about one row and one pixel after its centre pixel
// entered; once the item that completes its window is accepted, the result
// passes the line-store read, product and output registers. Each channel is
// filtered on its own with a signed 3x3 kernel, neighbours outside the frame
// count as zero and each sum is clamped to 0..255. After the last pixel of a
// frame, push items with flush set (or any item) to drain the remaining
// image_width+1 outputs; a flush word before the frame is complete is dropped.
// frame_end marks the last output of a frame, after which a new frame starts.
// Writing image_width or image_height restarts the frame; write configuration
// only while the block is idle. Stall on the pixel side is raised only while a
// result is held back by the output side.
module conv3x3_rgb_clamp_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int TAP_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [c3rgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [3*TAP_BITS-1:0]             cfg_data,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  logic [c3rgb_pkg::CH_W-1:0]        pixel_ch0,
  input  logic [c3rgb_pkg::CH_W-1:0]        pixel_ch1,
  input  logic [c3rgb_pkg::CH_W-1:0]        pixel_ch2,
  input  logic                              flush,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [c3rgb_pkg::CH_W-1:0]        out_ch0,
  output logic [c3rgb_pkg::CH_W-1:0]        out_ch1,
  output logic [c3rgb_pkg::CH_W-1:0]        out_ch2,
  output logic                              frame_end
);
  import c3rgb_pkg::*;

  localparam int KW  = 3 * TAP_BITS;
  localparam int WCW = $clog2(MAX_WIDTH);
  localparam int HCW = $clog2(MAX_HEIGHT);
  localparam int HRW = $clog2(MAX_HEIGHT + 2);
  localparam int PW  = TAP_BITS + CH_W + 1;
  localparam int SW  = PW + 4;
  localparam int W_RST_LAST = ((MAX_WIDTH  < 1024) ? MAX_WIDTH  : 1024) - 1;
  localparam int H_RST_LAST = ((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024) - 1;

  typedef struct packed {
    logic             emit;
    logic [WCW-1:0]   col;
    logic [PIX_W-1:0] pix;
    logic             top_off;
    logic             bot_off;
    logic             lft_off;
    logic             rgt_off;
    logic             fend;
    logic             restart;
  } s1_t;

  // configuration state
  logic [KW-1:0]  kern_top, kern_mid, kern_bot;
  logic [KW-1:0]  kern [3];
  logic [WCW-1:0] w_last;
  logic [HCW-1:0] h_last;
  logic [31:0]    size_raw, w_cfg_full, h_cfg_full;
  logic           size_wr;

  // frame position
  logic [WCW-1:0] in_col, out_col;
  logic [HRW-1:0] in_row;
  logic [HCW-1:0] out_row;
  logic           drained, pending, col_last, out_col_last, out_row_last, fend_now;
  logic           accept, take;

  // pipeline
  s1_t            s1, s1_next;
  logic           s1_valid, s1_fire, s1_free;
  logic           s2_valid, s2_adv, s2_fend, out_ld;
  logic signed [PW-1:0] prod_next [3][3][3];
  logic signed [PW-1:0] prod_q    [3][3][3];
  logic [CH_W-1:0] clamp_val [3];

  // line stores and forwarding
  logic [WCW-1:0]   raddr;
  logic [PIX_W-1:0] rd_a, rd_b, a_cur, b_cur;
  logic             lw_valid, lw_hit;
  logic [WCW-1:0]   lw_addr;
  logic [PIX_W-1:0] lw_a, lw_b;
  logic [PIX_W-1:0] newcol [3];
  logic [PIX_W-1:0] win_l [3];
  logic [PIX_W-1:0] win_c [3];

  // size written: 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    size_raw = 32'(cfg_data[SIZE_W-1:0]);
    if (size_raw == 32'd0) begin
      w_cfg_full = '0;
      h_cfg_full = '0;
    end else begin
      w_cfg_full = (size_raw > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH - 1)  : size_raw - 32'd1;
      h_cfg_full = (size_raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT - 1) : size_raw - 32'd1;
    end
  end

  assign size_wr = cfg_write &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last   <= WCW'(W_RST_LAST);
      h_last   <= HCW'(H_RST_LAST);
      kern_top <= KTOP_RST[KW-1:0];
      kern_mid <= KMID_RST[KW-1:0];
      kern_bot <= KBOT_RST[KW-1:0];
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_last   <= w_cfg_full[WCW-1:0];
        REG_IMAGE_HEIGHT: h_last   <= h_cfg_full[HCW-1:0];
        REG_KERNEL_TOP:   kern_top <= cfg_data;
        REG_KERNEL_MID:   kern_mid <= cfg_data;
        REG_KERNEL_BOT:   kern_bot <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kern[0] = kern_top;
  assign kern[1] = kern_mid;
  assign kern[2] = kern_bot;

  // frame position decode
  assign drained      = in_row > HRW'(h_last);
  assign pending      = (in_row > HRW'(1)) || (in_row == HRW'(1) && in_col != '0);
  assign col_last     = in_col == w_last;
  assign out_col_last = out_col == w_last;
  assign out_row_last = out_row == h_last;
  assign fend_now     = out_row_last && out_col_last;

  // handshake and flow control
  assign out_ld    = !res_valid || !res_stall;
  assign s2_adv    = !s2_valid || out_ld;
  assign s1_fire   = s1_valid && (!s1.emit || s2_adv);
  assign s1_free   = !s1_valid || s1_fire;
  assign pix_stall = !s1_free;
  assign accept    = pix_valid && !pix_stall;
  assign take      = accept && !(flush && !drained);

  // frame counters
  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      if (pending && fend_now) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col <= col_last ? '0 : in_col + WCW'(1);
        if (col_last) begin
          in_row <= in_row + HRW'(1);
        end
        if (pending) begin
          out_col <= out_col_last ? '0 : out_col + WCW'(1);
          if (out_col_last) begin
            out_row <= out_row + HCW'(1);
          end
        end
      end
    end
  end

  // stage 1 control word
  always_comb begin
    s1_next.emit    = pending;
    s1_next.col     = in_col;
    s1_next.pix     = drained ? '0 : {pixel_ch2, pixel_ch1, pixel_ch0};
    s1_next.top_off = out_row == '0;
    s1_next.bot_off = out_row_last;
    s1_next.lft_off = out_col == '0;
    s1_next.rgt_off = out_col_last || (in_col == '0);
    s1_next.fend    = fend_now;
    s1_next.restart = pending && fend_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && take) begin
      s1 <= s1_next;
    end
  end

  // line stores: a holds the previous row, b the row before it
  assign raddr = take ? in_col : s1.col;

  c3rgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1.col),
    .wdata (s1.pix),
    .raddr (raddr),
    .rdata (rd_a)
  );

  c3rgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1.col),
    .wdata (a_cur),
    .raddr (raddr),
    .rdata (rd_b)
  );

  // forward the last write when it hits the entry being read
  assign lw_hit = lw_valid && (lw_addr == s1.col);
  assign a_cur  = lw_hit ? lw_a : rd_a;
  assign b_cur  = lw_hit ? lw_b : rd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (s1_fire) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      lw_addr <= s1.col;
      lw_a    <= s1.pix;
      lw_b    <= a_cur;
    end
  end

  assign newcol[0] = b_cur;
  assign newcol[1] = a_cur;
  assign newcol[2] = s1.pix;

  // window: left and centre columns; right column is the incoming one
  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      for (int r = 0; r < 3; r++) begin
        win_l[r] <= '0;
        win_c[r] <= '0;
      end
    end else if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_l[r] <= s1.restart ? '0 : win_c[r];
        win_c[r] <= s1.restart ? '0 : newcol[r];
      end
    end
  end

  // tap products with frame-edge masking
  always_comb begin
    logic [PIX_W-1:0]           px;
    logic [CH_W-1:0]            val;
    logic                       off;
    logic signed [TAP_BITS-1:0] tp;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          px  = (j == 0) ? win_l[i] : ((j == 1) ? win_c[i] : newcol[i]);
          off = (i == 0 && s1.top_off) || (i == 2 && s1.bot_off) ||
                (j == 0 && s1.lft_off) || (j == 2 && s1.rgt_off);
          val = off ? '0 : px[ch*CH_W +: CH_W];
          tp  = kern[i][j*TAP_BITS +: TAP_BITS];
          prod_next[ch][i][j] = tp * $signed({1'b0, val});
        end
      end
    end
  end

  // stage 2: product register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_fire && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_fire && s1.emit) begin
      prod_q  <= prod_next;
      s2_fend <= s1.fend;
    end
  end

  // sum of nine products and clamp to 0..255
  always_comb begin
    logic signed [SW-1:0] sum;
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sum = sum + SW'(prod_q[ch][i][j]);
        end
      end
      if (sum[SW-1]) begin
        clamp_val[ch] = PIX_MIN;
      end else if (sum[SW-2:CH_W] != '0) begin
        clamp_val[ch] = PIX_MAX;
      end else begin
        clamp_val[ch] = sum[CH_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ld) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && s2_valid) begin
      out_ch0   <= clamp_val[0];
      out_ch1   <= clamp_val[1];
      out_ch2   <= clamp_val[2];
      frame_end <= s2_fend;
    end
  end

endmodule

>>> src/c3rgb_chk.sv
// port-level checker for the 3x3 rgb filter, bound to the top level
// depends on conv3x3_rgb_clamp_filter_assert.svh
`include "conv3x3_rgb_clamp_filter_assert.svh"

module c3rgb_chk (
  input logic       clk,
  input logic       rst,
  input logic       pix_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_ch0,
  input logic [7:0] out_ch1,
  input logic [7:0] out_ch2,
  input logic       frame_end
);

  // the pixel side is only held back by a result that cannot leave
  `C3RGB_ASSERT_IMP(a_stall_from_out, pix_stall, res_valid && res_stall)

  // a held result keeps its word
  `C3RGB_ASSERT_NXT(a_out_hold, res_valid && res_stall, res_valid && $stable(out_ch0) && $stable(out_ch1) && $stable(out_ch2) && $stable(frame_end))

  // reset empties the pipeline
  `C3RGB_ASSERT_RST(a_reset_empty, rst, !res_valid && !pix_stall)

endmodule

bind conv3x3_rgb_clamp_filter c3rgb_chk u_c3rgb_chk (.*);
